FILE: hdl/rtpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpa_pkg: shared types and codes of the region table page allocator
// Holds the scan item that travels down the cell chain, the table write
// bundle broadcast to every cell, the controller states and the codes.
// ----------------------------------------------------------------------------
package rtpa_pkg;

    // Index field width; covers a table of up to 256 entries.
    localparam int IDX_W = 8;

    // Item function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] REG_USABLE_TYPE = 2'd1;

    typedef logic [IDX_W-1:0] t_idx;

    // Scan item handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic        valid;
        logic [63:0] req;
        logic        have;
        t_idx        pick;
        logic [63:0] base;
        logic [63:0] rem;
    } t_token;

    // Table write broadcast to all cells.
    typedef struct packed {
        logic        load;
        logic        update;
        t_idx        idx;
        logic [63:0] base;
        logic [63:0] len;
        logic        usable;
    } t_cell_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ROUND
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/region_table_page_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// region_table_page_allocator: top-down page allocator over a region table
// A chain of cells holds the region entries; an allocation walks the chain,
// then the carve address is rounded and the chosen entry is shortened.
//
//   Channel   Handshake            Payload
//   input     start / busy         i_func, i_entry_index, i_entry_base,
//                                  i_entry_length, i_entry_type,
//                                  i_request_length
//   result    o_done (strobe)      o_found, o_alloc_address,
//                                  o_chosen_index, o_remaining_length
//   config    i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// A load item, and an allocate item whose request overflows on rounding,
// give their result in the cycle after acceptance and leave busy low.
// An allocate item that finds an entry passes every cell of the chain for the
// scan, then forms the carve sum, then rounds and writes back. One that finds
// no entry ends after the scan.
// The synchronous reset clears control only; the table holds garbage until
// loaded. Results are shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module region_table_page_allocator
    import rtpa_pkg::*;
#(
    parameter int MAX_ENTRIES = 32,
    parameter int PAGE_SHIFT  = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_func,
    input  wire logic [4:0]  i_entry_index,
    input  wire logic [63:0] i_entry_base,
    input  wire logic [63:0] i_entry_length,
    input  wire logic [31:0] i_entry_type,
    input  wire logic [63:0] i_request_length,
    output logic             o_done,
    output logic             o_found,
    output logic [63:0]      o_alloc_address,
    output logic [4:0]       o_chosen_index,
    output logic [63:0]      o_remaining_length,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

    t_state      r_state;
    t_state      n_state;
    logic [5:0]  r_entry_count;
    logic [31:0] r_usable_type;

    logic        r_done,  n_done;
    logic        r_found, n_found;
    logic [63:0] r_addr,  n_addr;
    logic [4:0]  r_idx,   n_idx;
    logic [63:0] r_rem,   n_rem;
    logic [63:0] r_carve, n_carve;
    t_idx        r_pick,  n_pick;
    logic [63:0] r_prem,  n_prem;

    logic        accept;
    logic        slot_ok;
    logic [64:0] req_sum;
    logic [64:0] addr_sum;
    t_cell_wr    cell_wr;
    t_token      head;
    t_token      chain [0:MAX_ENTRIES];
    t_token      tail;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign slot_ok  = {4'b0000, i_entry_index} < 9'(MAX_ENTRIES);
    assign req_sum  = {1'b0, i_request_length} + {1'b0, PAGE_MASK};
    assign addr_sum = {1'b0, r_carve} + {1'b0, PAGE_MASK};
    assign chain[0] = head;
    assign tail     = chain[MAX_ENTRIES];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= 6'd0;
            r_usable_type <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENTRY_COUNT: r_entry_count <= i_cfg_wdata[5:0];
                REG_USABLE_TYPE: r_usable_type <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The chain of cells, one per table entry.
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        rtpa_cell #(
            .CELL_IDX(k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_entry_count(r_entry_count),
            .i_wr         (cell_wr),
            .i_tok        (chain[k]),
            .o_tok        (chain[k+1])
        );
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_ALLOC && !req_sum[64]) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tail.valid) begin
                    n_state = tail.have ? S_ROUND : S_IDLE;
                end
            end
            S_ROUND: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs, table writes and scan injection.
    always_comb begin
        n_done   = 1'b0;
        n_found  = 1'b0;
        n_addr   = 64'd0;
        n_idx    = 5'd0;
        n_rem    = 64'd0;
        n_carve  = r_carve;
        n_pick   = r_pick;
        n_prem   = r_prem;

        cell_wr.load   = 1'b0;
        cell_wr.update = 1'b0;
        cell_wr.idx    = t_idx'(i_entry_index);
        cell_wr.base   = i_entry_base;
        cell_wr.len    = i_entry_length;
        cell_wr.usable = (i_entry_type == r_usable_type);

        head.valid = 1'b0;
        head.req   = req_sum[63:0] & ~PAGE_MASK;
        head.have  = 1'b0;
        head.pick  = '0;
        head.base  = 64'd0;
        head.rem   = 64'd0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_LOAD) begin
                        n_done       = 1'b1;
                        cell_wr.load = slot_ok;
                    end else if (req_sum[64]) begin
                        n_done = 1'b1;
                    end else begin
                        head.valid = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (tail.valid) begin
                    if (!tail.have) begin
                        n_done = 1'b1;
                    end else begin
                        n_carve = tail.base + tail.rem;
                        n_pick  = tail.pick;
                        n_prem  = tail.rem;
                    end
                end
            end
            S_ROUND: begin
                n_done = 1'b1;
                if (!addr_sum[64]) begin
                    n_found        = 1'b1;
                    n_addr         = addr_sum[63:0] & ~PAGE_MASK;
                    n_idx          = r_pick[4:0];
                    n_rem          = r_prem;
                    cell_wr.update = 1'b1;
                    cell_wr.idx    = r_pick;
                    cell_wr.len    = r_prem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_found <= n_found;
        r_addr  <= n_addr;
        r_idx   <= n_idx;
        r_rem   <= n_rem;
        r_carve <= n_carve;
        r_pick  <= n_pick;
        r_prem  <= n_prem;
    end

    assign o_done             = r_done;
    assign o_found            = r_found;
    assign o_alloc_address    = r_addr;
    assign o_chosen_index     = r_idx;
    assign o_remaining_length = r_rem;

endmodule
`default_nettype wire

FILE: hdl/rtpa_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpa_cell: one region table entry of the allocator chain
// Stores base, length and usable mark of one entry. The scan item passes
// through a register here; a qualifying entry replaces the pick it carries.
// ----------------------------------------------------------------------------
module rtpa_cell
    import rtpa_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic [5:0] i_entry_count,
    input  wire t_cell_wr i_wr,
    input  wire t_token   i_tok,
    output t_token        o_tok
);

    localparam t_idx MY_IDX = t_idx'(CELL_IDX);

    logic [63:0] r_base;
    logic [63:0] r_len;
    logic        r_usable;
    t_token      r_tok;
    t_token      n_tok;
    logic [64:0] diff;
    logic        active;
    logic        hit;

    // Entry storage: loads write all fields, a carve rewrites the length.
    always_ff @(posedge i_clk) begin
        if (i_wr.load && i_wr.idx == MY_IDX) begin
            r_base   <= i_wr.base;
            r_len    <= i_wr.len;
            r_usable <= i_wr.usable;
        end else if (i_wr.update && i_wr.idx == MY_IDX) begin
            r_len <= i_wr.len;
        end
    end

    // Length minus request gives both the strict compare and the remainder.
    assign diff   = {1'b0, r_len} - {1'b0, i_tok.req};
    assign active = 9'(CELL_IDX) < {3'b000, i_entry_count};
    assign hit    = i_tok.valid && active && r_usable && !diff[64] && (diff[63:0] != 64'd0);

    // Later entries win, so a hit simply overwrites the carried pick.
    always_comb begin
        n_tok = i_tok;
        if (hit) begin
            n_tok.have = 1'b1;
            n_tok.pick = MY_IDX;
            n_tok.base = r_base;
            n_tok.rem  = diff[63:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.req  <= n_tok.req;
        r_tok.have <= n_tok.have;
        r_tok.pick <= n_tok.pick;
        r_tok.base <= n_tok.base;
        r_tok.rem  <= n_tok.rem;
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire
